// ===== rtl/pet_pkg.sv =====
// Shared types and constants for the Prewitt edge threshold block.
// No dependencies; imported by every module under rtl/ except pet_ram.
package pet_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 12;
  localparam int THR_W      = 11;
  localparam int GRAD_W     = 11;
  localparam int SQ_W       = 20;
  localparam int MAG_W      = 21;
  localparam int THR2_W     = 22;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESH = 2'd2;

  localparam logic [IMG_W_W-1:0] IMG_W_RST = 11'd640;
  localparam logic [IMG_H_W-1:0] IMG_H_RST = 12'd480;
  localparam logic [THR_W-1:0]   THR_RST   = 11'd100;

  localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
  localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

  // one window column, top row first
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } pet_col_t;

  // control of a beat leaving the line store read
  typedef struct packed {
    logic valid;
    logic res;
    logic last;
  } pet_s1_t;

  typedef struct packed {
    logic                     valid;
    logic                     last;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
  } pet_grad_t;

  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] edge_value;
  } pet_res_t;

endpackage

// ===== rtl/pet_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module pet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pet_window.sv =====
// 3x3 window column registers and Prewitt gradient stage.
// Depends on pet_pkg.
module pet_window (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pet_pkg::pet_s1_t               ctl_i,
  input  logic [pet_pkg::PIX_W-1:0]      px_i,
  input  logic [pet_pkg::PIX_W-1:0]      up1_i,
  input  logic [pet_pkg::PIX_W-1:0]      up2_i,
  output pet_pkg::pet_grad_t             grad_o
);
  import pet_pkg::*;

  // win_q[1] is the most recent column, win_q[0] the one before it
  pet_col_t  win_q [2];
  pet_col_t  col_new;
  pet_grad_t grad_q, grad_d;
  logic [9:0] sum_new, sum_old, sum_top, sum_bot;

  always_comb begin
    col_new.top = up2_i;
    col_new.mid = up1_i;
    col_new.bot = px_i;
    sum_new = 10'(col_new.top) + 10'(col_new.mid) + 10'(col_new.bot);
    sum_old = 10'(win_q[0].top) + 10'(win_q[0].mid) + 10'(win_q[0].bot);
    sum_top = 10'(win_q[0].top) + 10'(win_q[1].top) + 10'(col_new.top);
    sum_bot = 10'(win_q[0].bot) + 10'(win_q[1].bot) + 10'(col_new.bot);
    grad_d.valid = ctl_i.valid && ctl_i.res;
    grad_d.last  = ctl_i.last;
    grad_d.gx    = $signed({1'b0, sum_new}) - $signed({1'b0, sum_old});
    grad_d.gy    = $signed({1'b0, sum_top}) - $signed({1'b0, sum_bot});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q[0] <= '0;
      win_q[1] <= '0;
      grad_q   <= '0;
    end else begin
      grad_q <= grad_d;
      if (ctl_i.valid) begin
        win_q[0] <= win_q[1];
        win_q[1] <= col_new;
      end
    end
  end

  assign grad_o = grad_q;

endmodule

// ===== rtl/pet_mag.sv =====
// Squared gradient magnitude against squared threshold.
// Depends on pet_pkg.
module pet_mag (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pet_pkg::pet_grad_t         grad_i,
  input  logic [pet_pkg::THR_W-1:0]  thr_i,
  output logic                       pend_o,
  output logic                       res_valid_o,
  output pet_pkg::pet_res_t          res_o
);
  import pet_pkg::*;

  logic signed [GRAD_W-1:0] gx, gy;
  logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
  logic [THR2_W-1:0] thr_sq;
  logic              valid_q, last_q;
  logic [SQ_W-1:0]   gx2_q, gy2_q;
  logic [THR2_W-1:0] thr2_q;
  logic [MAG_W-1:0]  mag;

  always_comb begin
    gx     = grad_i.gx;
    gy     = grad_i.gy;
    gx_sq  = gx * gx;
    gy_sq  = gy * gy;
    thr_sq = THR2_W'(thr_i) * THR2_W'(thr_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= grad_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= grad_i.last;
    gx2_q  <= gx_sq[SQ_W-1:0];
    gy2_q  <= gy_sq[SQ_W-1:0];
    thr2_q <= thr_sq;
  end

  assign mag              = MAG_W'(gx2_q) + MAG_W'(gy2_q);
  assign pend_o           = valid_q;
  assign res_valid_o      = valid_q;
  assign res_o.last       = last_q;
  assign res_o.edge_value = (THR2_W'(mag) > thr2_q) ? EDGE_ON : EDGE_OFF;

endmodule

// ===== rtl/pet_ofifo.sv =====
// Small register FIFO holding finished result beats.
// Depends on pet_pkg.
module pet_ofifo #(
  parameter int DEPTH = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_i,
  input  pet_pkg::pet_res_t            wdata_i,
  input  logic                         rd_i,
  output pet_pkg::pet_res_t            rdata_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   cnt_o
);
  import pet_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pet_res_t         buf_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_rd;

  assign do_rd = rd_i && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
      end
      case ({wr_i, do_rd})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      buf_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o = buf_q[rptr_q];
  assign empty_o = (cnt_q == '0);
  assign cnt_o   = cnt_q;

endmodule

// ===== rtl/prewitt_edge_threshold.sv =====
// Top level: streaming 3x3 Prewitt edge detector with magnitude threshold.
// Depends on pet_pkg, pet_ram, pet_window, pet_mag, pet_ofifo.
//
//   channel | signals                                   | beat
//   --------+-------------------------------------------+------------------------
//   in      | in_valid_i / in_ready_o, pixel_i          | one pixel, raster order
//   out     | out_valid_o / out_ready_i, edge_value_o,  | one interior result
//           | frame_last_o                              |
//   cfg     | cfg_we_i, cfg_idx_i, cfg_data_i           | one register write
//
// One pixel per clock while the credit count has room. A result passes line store
// read, gradients, squares and compare on its way into the output FIFO.
// Both previous rows share one line store RAM, read at accept and written back
// the cycle after; addresses of neighboring beats always differ.
// Output stalls back up through a credit count over the pipeline and FIFO;
// input is taken as long as OUT_DEPTH has room. No clearing pass after reset.
module prewitt_edge_threshold #(
  parameter int MAX_WIDTH = 1024,
  parameter int OUT_DEPTH = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [pet_pkg::PIX_W-1:0]         pixel_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [pet_pkg::PIX_W-1:0]         edge_value_o,
  output logic                              frame_last_o,
  input  logic                              cfg_we_i,
  input  logic [pet_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pet_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import pet_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int CRD_W = CNT_W + 1;

  logic [IMG_W_W-1:0] width_q;
  logic [IMG_H_W-1:0] height_q;
  logic [THR_W-1:0]   thr_q;

  logic [CW-1:0]      col_q, col_d;
  logic [IMG_H_W-1:0] row_q, row_d;
  logic [WW-1:0]      w_raw, w_eff, w_last;
  logic [IMG_H_W-1:0] h_eff, h_last;
  logic               last_col, last_row, accept;

  pet_s1_t            s1_q, s1_d;
  logic [PIX_W-1:0]   s1_px_q;
  logic [CW-1:0]      s1_addr_q;
  logic [2*PIX_W-1:0] ram_rdata, ram_wdata;

  pet_grad_t          grad;
  logic               mag_pend, res_valid;
  pet_res_t           res, head;
  logic               fifo_empty;
  logic [CNT_W-1:0]   fifo_cnt;
  logic [CRD_W-1:0]   used;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= IMG_W_RST;
      height_q <= IMG_H_RST;
      thr_q    <= THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_WIDTH:  width_q  <= cfg_data_i[IMG_W_W-1:0];
        CFG_IDX_HEIGHT: height_q <= cfg_data_i[IMG_H_W-1:0];
        CFG_IDX_THRESH: thr_q    <= cfg_data_i[THR_W-1:0];
        default:        ;
      endcase
    end
  end

  // frame position
  always_comb begin
    w_raw = WW'(width_q);
    if (w_raw < WW'(3)) begin
      w_eff = WW'(3);
    end else if (w_raw > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    w_last   = w_eff - WW'(1);
    h_eff    = (height_q < IMG_H_W'(3)) ? IMG_H_W'(3) : height_q;
    h_last   = h_eff - IMG_H_W'(1);
    last_col = WW'(col_q) >= w_last;
    last_row = row_q >= h_last;

    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + IMG_H_W'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end

    s1_d.valid = accept;
    s1_d.res   = accept && (row_q >= IMG_H_W'(2)) && (col_q >= CW'(2));
    s1_d.last  = last_col && last_row;
  end

  // credit: result beats in the pipeline plus those parked in the FIFO
  assign used = CRD_W'(fifo_cnt) + CRD_W'(s1_q.valid && s1_q.res) + CRD_W'(grad.valid)
              + CRD_W'(mag_pend);
  assign in_ready_o = used < CRD_W'(OUT_DEPTH);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      s1_q  <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      s1_q  <= s1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q   <= pixel_i;
      s1_addr_q <= col_q;
    end
  end

  // upper byte: row before previous, lower byte: previous row
  assign ram_wdata = {ram_rdata[PIX_W-1:0], s1_px_q};

  pet_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_q.valid),
    .waddr_i (s1_addr_q),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  pet_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (s1_q),
    .px_i   (s1_px_q),
    .up1_i  (ram_rdata[PIX_W-1:0]),
    .up2_i  (ram_rdata[2*PIX_W-1:PIX_W]),
    .grad_o (grad)
  );

  pet_mag u_mag (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grad_i      (grad),
    .thr_i       (thr_q),
    .pend_o      (mag_pend),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  pet_ofifo #(
    .DEPTH (OUT_DEPTH)
  ) u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_valid),
    .wdata_i (res),
    .rd_i    (out_ready_i),
    .rdata_o (head),
    .empty_o (fifo_empty),
    .cnt_o   (fifo_cnt)
  );

  assign out_valid_o  = !fifo_empty;
  assign edge_value_o = head.edge_value;
  assign frame_last_o = head.last;

  // line store write-back never collides with the read of the next beat
  a_ram_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q.valid && accept |-> s1_addr_q != col_q)
    else $error("line store read and write hit the same entry");

  // credit keeps the FIFO from overflowing
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used <= CRD_W'(OUT_DEPTH))
    else $error("result beats in flight exceed output FIFO depth");

  // column counter wraps after the last column
  a_col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_col |=> col_q == '0)
    else $error("column counter did not wrap");

endmodule
